// File: rtl/core/multirow_sliding_window_mean_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multirow sliding-window mean core
// Each macro expands to a labeled concurrent assertion, or to nothing when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef MULTIROW_SLIDING_WINDOW_MEAN_CORE_MACROS_SVH
`define MULTIROW_SLIDING_WINDOW_MEAN_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge out of reset.
`define MSWM_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define MSWM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define MSWM_ASSERT(label, clk, rst_n, prop, msg)
`define MSWM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: rtl/core/mswm_pkg.sv
// ----------------------------------------------------------------------------
// mswm_pkg
// Types, sizes and codes shared by the sliding-window mean controller,
// datapath and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package mswm_pkg;

	localparam int MAX_COLUMNS = 64;
	localparam int MAX_ROWS    = 16;

	localparam int SLOT_W    = $clog2(MAX_COLUMNS);
	localparam int ROW_W     = $clog2(MAX_ROWS);
	localparam int ADDR_W    = SLOT_W + ROW_W;
	localparam int MEM_DEPTH = MAX_COLUMNS * MAX_ROWS;

	localparam int DATA_W     = 32;
	localparam int COL_W      = 7;
	localparam int ROWCFG_W   = 5;
	localparam int CNT_W      = COL_W;
	localparam int ACC_W      = DATA_W + SLOT_W;
	localparam int DIVCNT_W   = $clog2(ACC_W);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_COLUMNS = 2'd0;
	localparam cfg_idx_t CFG_ROWS    = 2'd1;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_OLDEST = 2'd1,
		MODE_MEAN   = 2'd2,
		MODE_NEWEST = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t                     mode;
		logic [ROW_W-1:0]          row;
		logic signed [DATA_W-1:0]  sample;
	} in_t;

	typedef struct packed {
		logic                      ok;
		logic signed [DATA_W-1:0]  result_value;
	} out_t;

	// controller to datapath
	typedef struct packed {
		logic item_load;
		logic ins_write;
		logic fail;
		logic ptr_load;
		logic rd_issue;
		logic rd_capture;
		logic div_load;
		logic div_step;
		logic mean_done;
		logic out_load;
		logic cfg_we;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		mode_t mode;
		logic  row_ok;
		logic  empty;
		logic  issue_last;
		logic  div_last;
	} dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/mswm_ctrl.sv
// ----------------------------------------------------------------------------
// mswm_ctrl
// Sequencer for the sliding-window mean core: takes one item at a time,
// steps the datapath through insert, read or mean-and-divide, and owns the
// output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none
`include "multirow_sliding_window_mean_core_macros.svh"

module mswm_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	output logic                    out_valid,
	input  wire logic               out_stall,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire mswm_pkg::dp_stat_t stat,
	output mswm_pkg::ctl_cmd_t      cmd
);
	import mswm_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE     = 10'b00_0000_0001,
		ST_DECODE   = 10'b00_0000_0010,
		ST_RD_ISSUE = 10'b00_0000_0100,
		ST_RD_CAPT  = 10'b00_0000_1000,
		ST_MEAN     = 10'b00_0001_0000,
		ST_DRAIN    = 10'b00_0010_0000,
		ST_DIV_LOAD = 10'b00_0100_0000,
		ST_DIV      = 10'b00_1000_0000,
		ST_FINISH   = 10'b01_0000_0000,
		ST_DONE     = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   decode_fail;

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	assign decode_fail = (stat.mode == MODE_INSERT) ? !stat.row_ok
		: (!stat.row_ok || stat.empty);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.cfg_we = cfg_valid;
				if (in_valid) begin
					cmd.item_load = 1'b1;
					state_d       = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (decode_fail) begin
					cmd.fail = 1'b1;
					state_d  = ST_DONE;
				end else if (stat.mode == MODE_INSERT) begin
					cmd.ins_write = 1'b1;
					state_d       = ST_DONE;
				end else begin
					cmd.ptr_load = 1'b1;
					state_d      = (stat.mode == MODE_MEAN) ? ST_MEAN : ST_RD_ISSUE;
				end
			end
			ST_RD_ISSUE: begin
				cmd.rd_issue = 1'b1;
				state_d      = ST_RD_CAPT;
			end
			ST_RD_CAPT: begin
				cmd.rd_capture = 1'b1;
				state_d        = ST_DONE;
			end
			ST_MEAN: begin
				cmd.rd_issue = 1'b1;
				if (stat.issue_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DIV_LOAD;
			end
			ST_DIV_LOAD: begin
				cmd.div_load = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				cmd.mean_done = 1'b1;
				state_d       = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`MSWM_ASSERT_NEXT(a_accept_blocks, clk, arst_n, in_valid && !in_stall, in_stall, "item accepted but next item not held off")
	`MSWM_ASSERT_NEXT(a_div_exit, clk, arst_n, state_q == ST_DIV && stat.div_last, state_q == ST_FINISH, "divider did not hand over to finish")
	`MSWM_ASSERT(a_load_free, clk, arst_n, !cmd.out_load || !out_valid_q || !out_stall, "result loaded over an untaken result")

endmodule

`default_nettype wire

// File: rtl/core/mswm_dp.sv
// ----------------------------------------------------------------------------
// mswm_dp
// Datapath of the sliding-window mean core: geometry registers, ring
// pointers, sample store, accumulator and radix-2 restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none
`include "multirow_sliding_window_mean_core_macros.svh"

module mswm_dp (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire mswm_pkg::ctl_cmd_t               cmd,
	input  wire mswm_pkg::in_t                    in_data,
	input  wire logic [mswm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [mswm_pkg::CFG_DATA_W-1:0]  cfg_data,
	output mswm_pkg::dp_stat_t                    stat,
	output mswm_pkg::out_t                        out_data
);
	import mswm_pkg::*;

	// geometry and ring state
	logic [COL_W-1:0]    cols_q;
	logic [ROWCFG_W-1:0] rows_q;
	logic [CNT_W-1:0]    count_q;
	logic [SLOT_W-1:0]   newest_q;
	logic [SLOT_W-1:0]   fill_q;

	// item and walk state
	in_t                 item_q;
	logic [SLOT_W-1:0]   ptr_q;
	logic [CNT_W-1:0]    k_q;
	logic [DATA_W-1:0]   store_q [MEM_DEPTH];
	logic [DATA_W-1:0]   rd_data_q;
	logic                rd_vld_q;
	logic [ACC_W-1:0]    acc_q;

	// divider
	logic [ACC_W-1:0]    quot_q;
	logic [CNT_W-1:0]    rem_q;
	logic                neg_q;
	logic [DIVCNT_W-1:0] div_cnt_q;

	// result
	logic                ok_q;
	logic [DATA_W-1:0]   value_q;
	out_t                out_q;

	logic                row_ok;
	logic                last_row;
	logic [SLOT_W-1:0]   fill_next;
	logic [SLOT_W-1:0]   ptr_next;
	logic [COL_W:0]      oldest_raw;
	logic [SLOT_W-1:0]   oldest;
	logic [COL_W-1:0]    cols_clamped;
	logic [ROWCFG_W-1:0] rows_clamped;
	logic [CNT_W:0]      rem_sh;
	logic [CNT_W:0]      rem_diff;
	logic [ACC_W-1:0]    acc_mag;
	logic [DATA_W-1:0]   quot_lo;

	assign row_ok   = {1'b0, item_q.row} < rows_q;
	assign last_row = ({1'b0, item_q.row} + ROWCFG_W'(1)) == rows_q;

	assign fill_next = (({1'b0, fill_q} + COL_W'(1)) == cols_q) ? '0 : fill_q + SLOT_W'(1);
	assign ptr_next  = (({1'b0, ptr_q} + COL_W'(1)) == cols_q) ? '0 : ptr_q + SLOT_W'(1);

	// oldest = (newest + cols + 1 - count) mod cols; the sum stays below 2*cols when the window is not empty
	assign oldest_raw = {2'b00, newest_q} + {1'b0, cols_q} + (COL_W+1)'(1) - {1'b0, count_q};
	assign oldest     = (oldest_raw >= {1'b0, cols_q})
		? SLOT_W'(oldest_raw - {1'b0, cols_q}) : SLOT_W'(oldest_raw);

	assign cols_clamped = (cfg_data[COL_W-1:0] == '0) ? COL_W'(1)
		: (cfg_data[COL_W-1:0] > COL_W'(MAX_COLUMNS)) ? COL_W'(MAX_COLUMNS)
		: cfg_data[COL_W-1:0];
	assign rows_clamped = (cfg_data[ROWCFG_W-1:0] == '0) ? ROWCFG_W'(1)
		: (cfg_data[ROWCFG_W-1:0] > ROWCFG_W'(MAX_ROWS)) ? ROWCFG_W'(MAX_ROWS)
		: cfg_data[ROWCFG_W-1:0];

	assign rem_sh   = {rem_q, quot_q[ACC_W-1]};
	assign rem_diff = rem_sh - {1'b0, count_q};
	assign acc_mag  = acc_q[ACC_W-1] ? (~acc_q + ACC_W'(1)) : acc_q;
	assign quot_lo  = quot_q[DATA_W-1:0];

	assign stat.mode       = item_q.mode;
	assign stat.row_ok     = row_ok;
	assign stat.empty      = (count_q == '0);
	assign stat.issue_last = ((k_q + CNT_W'(1)) == count_q);
	assign stat.div_last   = (div_cnt_q == DIVCNT_W'(ACC_W - 1));

	assign out_data = out_q;

	// geometry, ring pointers and walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q   <= COL_W'(MAX_COLUMNS);
			rows_q   <= ROWCFG_W'(MAX_ROWS);
			count_q  <= '0;
			newest_q <= '0;
			fill_q   <= '0;
			ptr_q    <= '0;
			k_q      <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= cmd.rd_issue;
			if (cmd.cfg_we) begin
				case (cfg_index)
					CFG_COLUMNS: begin
						cols_q   <= cols_clamped;
						count_q  <= '0;
						newest_q <= '0;
						fill_q   <= '0;
					end
					CFG_ROWS: begin
						rows_q   <= rows_clamped;
						count_q  <= '0;
						newest_q <= '0;
						fill_q   <= '0;
					end
					default: begin
					end
				endcase
			end else if (cmd.ins_write && last_row) begin
				if ({1'b0, count_q} < {1'b0, cols_q}) begin
					count_q <= count_q + CNT_W'(1);
				end
				newest_q <= fill_q;
				fill_q   <= fill_next;
			end
			if (cmd.ptr_load) begin
				ptr_q <= (item_q.mode == MODE_NEWEST) ? newest_q : oldest;
				k_q   <= '0;
			end else if (cmd.rd_issue) begin
				ptr_q <= ptr_next;
				k_q   <= k_q + CNT_W'(1);
			end
		end
	end

	// sample store, one port
	always_ff @(posedge clk) begin
		if (cmd.ins_write) begin
			store_q[{fill_q, item_q.row}] <= item_q.sample;
		end
		if (cmd.rd_issue) begin
			rd_data_q <= store_q[{ptr_q, item_q.row}];
		end
	end

	// item, accumulator, divider and result
	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			item_q <= in_data;
		end
		if (cmd.ptr_load) begin
			acc_q <= '0;
		end else if (rd_vld_q) begin
			acc_q <= acc_q + {{SLOT_W{rd_data_q[DATA_W-1]}}, rd_data_q};
		end
		if (cmd.div_load) begin
			quot_q    <= acc_mag;
			rem_q     <= '0;
			neg_q     <= acc_q[ACC_W-1];
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + DIVCNT_W'(1);
			if (!rem_diff[CNT_W]) begin
				rem_q  <= rem_diff[CNT_W-1:0];
				quot_q <= {quot_q[ACC_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[CNT_W-1:0];
				quot_q <= {quot_q[ACC_W-2:0], 1'b0};
			end
		end
		if (cmd.fail) begin
			ok_q    <= 1'b0;
			value_q <= (item_q.mode == MODE_MEAN) ? '1 : '0;
		end else if (cmd.ins_write) begin
			ok_q    <= 1'b1;
			value_q <= '0;
		end else if (cmd.rd_capture) begin
			ok_q    <= 1'b1;
			value_q <= rd_data_q;
		end else if (cmd.mean_done) begin
			ok_q    <= 1'b1;
			value_q <= neg_q ? (~quot_lo + DATA_W'(1)) : quot_lo;
		end
		if (cmd.out_load) begin
			out_q.ok           <= ok_q;
			out_q.result_value <= value_q;
		end
	end

	`MSWM_ASSERT(a_count_bound, clk, arst_n, count_q <= cols_q, "complete count above column count")
	`MSWM_ASSERT(a_slot_bound, clk, arst_n, fill_q < cols_q && newest_q < cols_q, "ring slot outside window")
	`MSWM_ASSERT(a_geom_range, clk, arst_n, cols_q != '0 && cols_q <= COL_W'(MAX_COLUMNS) && rows_q != '0 && rows_q <= ROWCFG_W'(MAX_ROWS), "geometry register out of range")

endmodule

`default_nettype wire

// File: rtl/core/multirow_sliding_window_mean_core.sv
// ----------------------------------------------------------------------------
// multirow_sliding_window_mean_core
// Ring of column slots with one Q16.16 value per row; inserts, oldest and
// newest column reads, and per-row mean over the complete columns.
// ----------------------------------------------------------------------------
// Items are taken one at a time: the core accepts an item, works it, and
// takes the next once the result sits in the output register (that result
// may still wait to be taken). The time of a row mean grows with the count
// of complete columns, up to 64, and is set by the single-port sample
// store, which reads one column per cycle, and by the radix-2 restoring
// divider, which retires one quotient bit per cycle over the 38-bit sum.
// The store needs no clearing after reset. Write columns_in_use (index 0)
// or rows_in_use (index 1) only while the core is idle; either write
// empties the window.
// ----------------------------------------------------------------------------
`default_nettype none

module multirow_sliding_window_mean_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// item channel
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire mswm_pkg::in_t                    in_data,
	// result channel
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output mswm_pkg::out_t                        out_data,
	// register write channel
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [mswm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [mswm_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import mswm_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;

	// Sequence each item: decode, then insert, read, or walk the store and
	// divide for a mean, then hold the result until the output register is free.
	mswm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Store, ring pointers, accumulator, divider and the output register;
	// a register transfer lands here through cmd.cfg_we.
	mswm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_data),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.stat      (stat),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
